>>> design/assert_macros.svh
// Assertion macros used by keypad_scan_debounce_core.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define KPSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

`define KPSD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`else

`define KPSD_ASSERT(lbl, clk, rst_n, prop)

`define KPSD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> design/kpsd_pkg.sv
package kpsd_pkg;

  localparam int NumColumns = 3;
  localparam int RowW       = 4;
  localparam int CodeW      = 8;
  localparam int CountW     = 16;

  typedef logic [RowW-1:0]   rows_t;
  typedef logic [CodeW-1:0]  code_t;
  typedef logic [CountW-1:0] count_t;

  localparam count_t ThresholdReset = 16'd150;
  localparam count_t CountMax       = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_PRESS   = 2'b01,
    PH_RELEASE = 2'b10
  } phase_t;

endpackage

>>> design/kpsd_in_if.sv
interface kpsd_in_if;
  import kpsd_pkg::*;

  logic  valid;
  logic  ready;
  rows_t rows_col0;
  rows_t rows_col1;
  rows_t rows_col2;

  modport source (output valid, output rows_col0, output rows_col1, output rows_col2,
                  input ready);
  modport sink (input valid, input rows_col0, input rows_col1, input rows_col2,
                output ready);
endinterface

>>> design/kpsd_out_if.sv
interface kpsd_out_if;
  import kpsd_pkg::*;

  logic  valid;
  logic  ready;
  code_t key_code;

  modport source (output valid, output key_code, input ready);
  modport sink (input valid, input key_code, output ready);
endinterface

>>> design/kpsd_encode.sv
module kpsd_encode (
  input  kpsd_pkg::rows_t rows_col0,
  input  kpsd_pkg::rows_t rows_col1,
  input  kpsd_pkg::rows_t rows_col2,
  output kpsd_pkg::code_t code
);
  import kpsd_pkg::*;

  rows_t rows_a [NumColumns];

  assign rows_a[0] = rows_col0;
  assign rows_a[1] = rows_col1;
  assign rows_a[2] = rows_col2;

  // Lower columns take priority, so they are visited last.
  always_comb begin
    code = '0;
    for (int c = NumColumns - 1; c >= 0; c--) begin
      if (rows_a[c] != '0) begin
        code = {rows_a[c], 4'(4'b0001 << c)};
      end
    end
  end

endmodule

>>> design/keypad_scan_debounce_core.sv
// Matrix keypad scanner with debounce. Each input beat is one scan sample of
// the row lines for the three columns; the lowest column with a row high gives
// the key code (row bits 7:4, one-hot column 2:0). A nonzero code must repeat
// on more than thr_r consecutive samples to register a press, then
// an all-zero sample must repeat likewise to register the release, at which
// point the pressed key is sent as one output beat. The block takes one sample
// per clock while the output is not stalled: the code is encoded into an input
// register, and the debounce state and result register are updated when that
// sample leaves the input register. A result beat that waits on out_ch.ready
// holds the next sample in the input register and stalls the input until it
// is taken. The user must write the threshold register through cfg_we and
// cfg_wdata only while no sample is in flight; the block does not enforce it.
`include "assert_macros.svh"

module keypad_scan_debounce_core (
  input  logic              clk,
  input  logic              rst_n,
  kpsd_in_if.sink           in_ch,
  kpsd_out_if.source        out_ch,
  input  logic              cfg_we,
  input  kpsd_pkg::count_t  cfg_wdata
);
  import kpsd_pkg::*;

  code_t  enc_code;
  logic   in_vld_r;
  code_t  code_r;
  logic   fire;

  count_t thr_r;
  phase_t phase_r, phase_nxt;
  count_t cnt_r, cnt_nxt;
  code_t  last_r, last_nxt;
  code_t  held_r, held_nxt;
  logic   emit;
  logic   same;
  count_t cnt_run;

  logic   out_vld_r;
  code_t  key_code_r;

  kpsd_encode u_encode (
    .rows_col0 (in_ch.rows_col0),
    .rows_col1 (in_ch.rows_col1),
    .rows_col2 (in_ch.rows_col2),
    .code      (enc_code)
  );

  assign fire        = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      code_r <= enc_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThresholdReset;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    last_nxt  = last_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    case (phase_r)
      PH_PRESS: same = (code_r == last_r) && (code_r != '0);
      PH_RELEASE: same = (code_r == '0);
      default: same = 1'b0;
    endcase
    if (!same) begin
      cnt_run = '0;
    end else if (cnt_r != CountMax) begin
      cnt_run = cnt_r + 1'b1;
    end else begin
      cnt_run = cnt_r;
    end
    cnt_nxt = cnt_run;
    case (phase_r)
      PH_PRESS: begin
        last_nxt = code_r;
        if (cnt_run > thr_r) begin
          held_nxt  = code_r;
          phase_nxt = PH_RELEASE;
          cnt_nxt   = '0;
        end
      end
      PH_RELEASE: begin
        if (cnt_run > thr_r) begin
          phase_nxt = PH_PRESS;
          cnt_nxt   = '0;
          last_nxt  = '0;
          emit      = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_PRESS;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRESS;
      cnt_r   <= '0;
      last_r  <= '0;
      held_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      key_code_r <= held_r;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.key_code = key_code_r;

  // A result appears only when a release is accepted in release phase.
  `KPSD_ASSERT(a_emit_from_release, clk, rst_n,
    $rose(out_vld_r) |-> $past(phase_r == PH_RELEASE))
  // Every phase change starts a fresh run.
  `KPSD_ASSERT(a_phase_change_clears, clk, rst_n,
    (phase_r != $past(phase_r)) |-> (cnt_r == '0))
  // A latched key always has a row and a column bit set.
  `KPSD_ASSERT(a_held_nonzero, clk, rst_n,
    (phase_r == PH_RELEASE) |-> (held_r != '0))

endmodule
